>>> src/kmr_pkg.sv
// ----------------------------------------------------------------------------
// kmr_pkg: shared types and constants of the k-mer reference matcher
// Item structs, internal command format, result kinds and base coding.
// ----------------------------------------------------------------------------
package kmr_pkg;

	localparam int unsigned REF_ENTRIES_DEF = 1024;
	localparam int unsigned KMER_BASES_DEF  = 256;
	localparam int unsigned KEY_WORDS       = 8;
	localparam int unsigned WORD_BASES      = 32;

	localparam logic [2:0] KIND_HIT  = 3'd0;
	localparam logic [2:0] KIND_MISS = 3'd1;
	localparam logic [2:0] KIND_END  = 3'd2;
	localparam logic [2:0] KIND_STORED = 3'd3;
	localparam logic [2:0] KIND_DUP  = 3'd4;
	localparam logic [2:0] KIND_FULL = 3'd5;

	localparam logic REQ_REF  = 1'b0;
	localparam logic REQ_BASE = 1'b1;

	localparam logic [3:0] SLOT_COMMIT = 4'd8;

	localparam logic [1:0] CMD_STAGE  = 2'd0;
	localparam logic [1:0] CMD_COMMIT = 2'd1;
	localparam logic [1:0] CMD_BASE   = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [63:0] ref_word;
		logic [3:0]  word_slot;
		logic [7:0]  base_char;
		logic        seq_last;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [31:0] ref_index;
		logic        repeat_flag;
		logic [7:0]  remainder_bases;
		logic        last_result;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] word;
		logic [2:0]  slot;
		logic [1:0]  code;
		logic        last;
	} cmd_t;

	function automatic logic [1:0] base_code(input logic [7:0] c);
		logic [1:0] r;
		r = 2'd0;
		if (c == 8'h41) r = 2'd0;
		else if (c == 8'h43) r = 2'd1;
		else if (c == 8'h47) r = 2'd2;
		else if (c == 8'h54) r = 2'd3;
		return r;
	endfunction

endpackage

>>> src/kmr_front.sv
// ----------------------------------------------------------------------------
// kmr_front: input classification
// Turns accepted items into commands; unused slots are dropped here.
// ----------------------------------------------------------------------------
module kmr_front (
	input  logic          req_valid,
	output logic          req_stall,
	input  kmr_pkg::req_t req,
	input  logic          q_full,
	output logic          q_push,
	output kmr_pkg::cmd_t q_cmd
);
	import kmr_pkg::*;

	logic useful;

	always_comb begin
		q_cmd.word = req.ref_word;
		q_cmd.slot = req.word_slot[2:0];
		q_cmd.code = base_code(req.base_char);
		q_cmd.last = req.seq_last;
		useful     = 1'b1;
		if (req.req_type == REQ_BASE) begin
			q_cmd.kind = CMD_BASE;
		end else if (req.word_slot == SLOT_COMMIT) begin
			q_cmd.kind = CMD_COMMIT;
		end else begin
			q_cmd.kind = CMD_STAGE;
			useful     = ~req.word_slot[3];
		end
	end

	assign req_stall = q_full;
	assign q_push    = req_valid & ~q_full & useful;

endmodule

>>> src/kmr_queue.sv
// ----------------------------------------------------------------------------
// kmr_queue: command queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module kmr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kmr_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output kmr_pkg::cmd_t dout
);
	import kmr_pkg::*;

	cmd_t       mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end

	assign full  = cnt_q[2];
	assign valid = cnt_q != 3'd0;
	assign dout  = mem_q[rd_q];

endmodule

>>> src/kmr_back.sv
// ----------------------------------------------------------------------------
// kmr_back: command execution
// Holds the key table, the base window and the result register.
// ----------------------------------------------------------------------------
module kmr_back #(
	parameter int unsigned REF_ENTRIES = kmr_pkg::REF_ENTRIES_DEF,
	parameter int unsigned KMER_BASES  = kmr_pkg::KMER_BASES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [8:0]    stride,
	input  logic          q_valid,
	input  kmr_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output kmr_pkg::rsp_t rsp
);
	import kmr_pkg::*;

	localparam int unsigned EW = $clog2(REF_ENTRIES);
	localparam int unsigned HW = $clog2(KMER_BASES + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_IDX  = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;
	localparam logic [2:0] ST_END  = 3'd6;

	logic [63:0] key_mem [REF_ENTRIES*KEY_WORDS];
	logic [31:0] idx_mem [REF_ENTRIES];

	logic [2:0]    st_q;
	logic [EW:0]   ent_q;
	logic [EW:0]   count_q;
	logic [2:0]    wrd_q;
	logic          commit_q;
	cmd_t          cmd_q;
	logic [63:0]   staged_q [KEY_WORDS];
	logic [1:0]    taps_q [KMER_BASES];
	logic [HW-1:0] held_q;
	logic [31:0]   prev_q;
	logic          have_prev_q;
	logic [2:0]    kind_q;
	logic [31:0]   idx_q;
	logic          rep_q;
	logic [63:0]   key_rd_q;
	logic [31:0]   idx_rd_q;
	logic          rsp_vld_q;
	rsp_t          rsp_q;

	logic [63:0]   win_word [KEY_WORDS];
	logic [63:0]   cmp_word;
	logic [8:0]    step;
	logic          slot_free;
	logic          rsp_load;
	logic [HW-1:0] held_inc;

	// The window is always the newest bases, oldest at tap 0.
	for (genvar i = 0; i < KEY_WORDS; i++) begin : g_word
		for (genvar j = 0; j < WORD_BASES; j++) begin : g_base
			if (i * WORD_BASES + j < KMER_BASES) begin : g_used
				assign win_word[i][2*j+1:2*j] = taps_q[i*WORD_BASES+j];
			end else begin : g_zero
				assign win_word[i][2*j+1:2*j] = 2'b00;
			end
		end
	end

	always_comb begin
		if (stride == 9'd0) step = 9'd1;
		else if (stride > 9'(KMER_BASES)) step = 9'(KMER_BASES);
		else step = stride;
	end

	assign cmp_word  = commit_q ? staged_q[wrd_q] : win_word[wrd_q];
	assign slot_free = ~rsp_vld_q | ~rsp_stall;
	assign rsp_load  = slot_free & ((st_q == ST_EMIT) | (st_q == ST_END));
	assign q_pop     = (st_q == ST_IDLE) & q_valid;
	assign held_inc  = held_q + HW'(1);

	always_ff @(posedge clk) begin
		key_rd_q <= key_mem[{ent_q[EW-1:0], wrd_q}];
		idx_rd_q <= idx_mem[ent_q[EW-1:0]];
		if (st_q == ST_WR) begin
			key_mem[{count_q[EW-1:0], wrd_q}] <= staged_q[wrd_q];
			if (wrd_q == 3'd0) idx_mem[count_q[EW-1:0]] <= cmd_q.word[31:0];
		end
		if (q_pop && q_cmd.kind == CMD_BASE) begin
			taps_q[KMER_BASES-1] <= q_cmd.code;
			for (int k = 0; k < KMER_BASES - 1; k++) taps_q[k] <= taps_q[k+1];
		end
		if (q_pop) cmd_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ent_q       <= '0;
			count_q     <= '0;
			wrd_q       <= '0;
			commit_q    <= 1'b0;
			held_q      <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			kind_q      <= KIND_HIT;
			idx_q       <= '0;
			rep_q       <= 1'b0;
			rsp_vld_q   <= 1'b0;
			rsp_q       <= '0;
			for (int k = 0; k < KEY_WORDS; k++) staged_q[k] <= '0;
		end else begin
			rsp_vld_q <= rsp_load | (rsp_vld_q & rsp_stall);
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						ent_q <= '0;
						wrd_q <= '0;
						idx_q <= '0;
						rep_q <= 1'b0;
						case (q_cmd.kind)
							CMD_STAGE: staged_q[q_cmd.slot] <= q_cmd.word;
							CMD_COMMIT: begin
								commit_q <= 1'b1;
								st_q     <= ST_RD;
							end
							CMD_BASE: begin
								commit_q <= 1'b0;
								held_q   <= held_inc;
								if (held_inc == HW'(KMER_BASES)) st_q <= ST_RD;
								else if (q_cmd.last) st_q <= ST_END;
							end
							default: st_q <= ST_IDLE;
						endcase
					end
				end
				ST_RD: begin
					if (ent_q == count_q) begin
						if (!commit_q) begin
							held_q <= HW'(10'(KMER_BASES) - {1'b0, step});
							kind_q <= KIND_MISS;
							st_q   <= ST_EMIT;
						end else if (count_q >= (EW+1)'(REF_ENTRIES)) begin
							kind_q <= KIND_FULL;
							st_q   <= ST_EMIT;
						end else begin
							st_q <= ST_WR;
						end
					end else begin
						st_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (key_rd_q != cmp_word) begin
						ent_q <= ent_q + (EW+1)'(1);
						wrd_q <= '0;
						st_q  <= ST_RD;
					end else if (wrd_q == 3'd7) begin
						if (commit_q) begin
							kind_q <= KIND_DUP;
							st_q   <= ST_EMIT;
						end else begin
							st_q <= ST_IDX;
						end
					end else begin
						wrd_q <= wrd_q + 3'd1;
						st_q  <= ST_RD;
					end
				end
				ST_IDX: begin
					kind_q      <= KIND_HIT;
					idx_q       <= idx_rd_q;
					rep_q       <= have_prev_q & (idx_rd_q == prev_q);
					prev_q      <= idx_rd_q;
					have_prev_q <= 1'b1;
					held_q      <= '0;
					st_q        <= ST_EMIT;
				end
				ST_WR: begin
					wrd_q <= wrd_q + 3'd1;
					if (wrd_q == 3'd7) begin
						count_q <= count_q + (EW+1)'(1);
						kind_q  <= KIND_STORED;
						st_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						rsp_q.result_kind           <= kind_q;
						rsp_q.ref_index             <= idx_q;
						rsp_q.repeat_flag           <= rep_q;
						rsp_q.remainder_bases       <= '0;
						rsp_q.last_result           <= commit_q | ~cmd_q.last;
						st_q <= (!commit_q && cmd_q.last) ? ST_END : ST_IDLE;
					end
				end
				ST_END: begin
					if (slot_free) begin
						rsp_q.result_kind     <= KIND_END;
						rsp_q.ref_index       <= '0;
						rsp_q.repeat_flag     <= 1'b0;
						rsp_q.remainder_bases <= 8'(held_q);
						rsp_q.last_result     <= 1'b1;
						held_q                <= '0;
						st_q                  <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

>>> src/kmer_reference_matcher.sv
// ----------------------------------------------------------------------------
// kmer_reference_matcher: dictionary match of 2-bit coded DNA windows
// Top level: stride register, front classifier, command queue, back end.
// ----------------------------------------------------------------------------
// Items enter a four-deep command queue at up to one per cycle while the
// queue is not full. A staging word or a base without a lookup is handled
// in the back end's idle state, and a sequence end then emits its result
// from the END state. Each lookup or commit scans the stored entries in
// order, reading and comparing them key word by key word from the key
// memory; a hit then fetches its index, a new entry writes its eight key
// words, and each result is held in the output register until taken. The
// table needs no clearing pass after reset: the entry count bounds every scan.
module kmer_reference_matcher #(
	parameter int unsigned REF_ENTRIES = kmr_pkg::REF_ENTRIES_DEF,
	parameter int unsigned KMER_BASES  = kmr_pkg::KMER_BASES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [8:0]    cfg_wdata,
	input  logic          req_valid,
	output logic          req_stall,
	input  kmr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output kmr_pkg::rsp_t rsp
);
	import kmr_pkg::*;

	logic [8:0] stride_q;
	logic       q_full;
	logic       q_push;
	logic       q_pop;
	logic       q_valid;
	cmd_t       q_in;
	cmd_t       q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) stride_q <= 9'd1;
		else if (cfg_we) stride_q <= cfg_wdata;
	end

	kmr_front u_front (
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.q_full(q_full), .q_push(q_push), .q_cmd(q_in)
	);

	kmr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din(q_in), .full(q_full),
		.pop(q_pop), .valid(q_valid), .dout(q_out)
	);

	kmr_back #(.REF_ENTRIES(REF_ENTRIES), .KMER_BASES(KMER_BASES)) u_back (
		.clk(clk), .arst_n(arst_n), .stride(stride_q), .q_valid(q_valid),
		.q_cmd(q_out), .q_pop(q_pop), .rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall), .rsp(rsp)
	);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue read while empty");
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind != KIND_HIT |-> rsp.ref_index == 32'd0)
		else $error("index on a result that is not a hit");
	a_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind != KIND_END |-> rsp.remainder_bases == 8'd0)
		else $error("remainder on a result that is not a sequence end");
`endif

endmodule
